/* rtl/upds_pkg.sv */
// upds_pkg: shared types and constants for the up/down pot wiper sequencer
// used by upds_step, upds_state and the top level under rtl; depends on nothing
`default_nettype none

package upds_pkg;

	// default full-scale wiper position (end B)
	localparam int unsigned MAX_POSITION_DEF = 63;
	// device power-up wiper position
	localparam int unsigned POWER_UP_POS = 'h1f;

	localparam logic [1:0] OP_TICK    = 2'd0;
	localparam logic [1:0] OP_SET     = 2'd1;
	localparam logic [1:0] OP_FORCE_B = 2'd2;

	typedef enum logic [1:0] {
		PH_IDLE       = 2'd0,
		PH_DIR_SET    = 2'd1,
		PH_TO_LOAD    = 2'd2,
		PH_TO_TRIGGER = 2'd3
	} phase_t;

	// pin and sequence state passed between step logic and state register
	typedef struct packed {
		phase_t phase;
		logic   ud;
		logic   cs;
	} pins_t;

	localparam pins_t PINS_RESET = '{phase: PH_IDLE, ud: 1'b0, cs: 1'b1};

endpackage

`default_nettype wire

/* rtl/upds_in_reg.sv */
// upds_in_reg: input register stage for command transactions
// depends on nothing but the handshake from the top level
`default_nettype none

module upds_in_reg (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [1:0] opcode,
	input  wire logic [7:0] target_value,
	input  wire logic       take,
	output logic            valid_s1,
	output logic [1:0]      opcode_s1,
	output logic [7:0]      target_s1
);

	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			opcode_s1 <= opcode;
			target_s1 <= target_value;
		end
	end

endmodule

`default_nettype wire

/* rtl/upds_step.sv */
// upds_step: combinational next state for one command (tick, set target, force to end b)
// depends on upds_pkg
`default_nettype none

module upds_step #(
	parameter int unsigned MAX_POSITION = upds_pkg::MAX_POSITION_DEF,
	parameter int unsigned POS_W        = $clog2(MAX_POSITION + 1)
) (
	input  wire logic [1:0]         opcode,
	input  wire logic [7:0]         target_value,
	input  wire logic [POS_W-1:0]   now_q,
	input  wire logic [POS_W-1:0]   goal_q,
	input  wire upds_pkg::pins_t    pins_q,
	output logic [POS_W-1:0]        now_d,
	output logic [POS_W-1:0]        goal_d,
	output upds_pkg::pins_t         pins_d
);

	localparam int unsigned CW = ((POS_W > 8) ? POS_W : 8) + 1;
	localparam logic [CW-1:0] MAX_X = CW'(MAX_POSITION);

	logic [CW-1:0]    tv_x;
	logic [POS_W-1:0] clamped;
	logic             at_goal;
	logic             going_up;

	assign tv_x     = {{(CW-8){target_value[7]}}, target_value};
	assign at_goal  = (now_q == goal_q);
	assign going_up = (goal_q > now_q);

	always_comb begin
		if (target_value[7]) begin
			clamped = '0;
		end else if (tv_x > MAX_X) begin
			clamped = POS_W'(MAX_POSITION);
		end else begin
			clamped = tv_x[POS_W-1:0];
		end
	end

	always_comb begin
		now_d  = now_q;
		goal_d = goal_q;
		pins_d = pins_q;
		case (opcode)
			upds_pkg::OP_TICK: begin
				if (at_goal) begin
					pins_d.cs    = 1'b1;
					pins_d.phase = upds_pkg::PH_IDLE;
				end else begin
					case (pins_q.phase)
						upds_pkg::PH_IDLE: begin
							pins_d.ud    = going_up;
							pins_d.phase = upds_pkg::PH_DIR_SET;
						end
						upds_pkg::PH_DIR_SET: begin
							pins_d.cs    = 1'b0;
							pins_d.phase = upds_pkg::PH_TO_LOAD;
						end
						upds_pkg::PH_TO_LOAD: begin
							pins_d.ud    = !pins_q.ud;
							pins_d.phase = upds_pkg::PH_TO_TRIGGER;
						end
						default: begin
							// trigger edge: wiper moves one step toward goal
							pins_d.ud    = !pins_q.ud;
							now_d        = going_up ? now_q + POS_W'(1) : now_q - POS_W'(1);
							pins_d.phase = upds_pkg::PH_TO_LOAD;
						end
					endcase
				end
			end
			upds_pkg::OP_SET: begin
				goal_d = clamped;
			end
			upds_pkg::OP_FORCE_B: begin
				now_d  = POS_W'(MAX_POSITION);
				goal_d = '0;
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

/* rtl/upds_state.sv */
// upds_state: wiper and pin state registers, which also serve as the result register
// depends on upds_pkg
`default_nettype none

module upds_state #(
	parameter int unsigned MAX_POSITION = upds_pkg::MAX_POSITION_DEF,
	parameter int unsigned POS_W        = $clog2(MAX_POSITION + 1)
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               take,
	input  wire logic               out_ready,
	input  wire logic [POS_W-1:0]   now_d,
	input  wire logic [POS_W-1:0]   goal_d,
	input  wire upds_pkg::pins_t    pins_d,
	output logic                    out_valid_q,
	output logic [POS_W-1:0]        now_q,
	output logic [POS_W-1:0]        goal_q,
	output upds_pkg::pins_t         pins_q
);

	localparam int unsigned RESET_POS =
		(upds_pkg::POWER_UP_POS > MAX_POSITION) ? MAX_POSITION : upds_pkg::POWER_UP_POS;

	// state only moves when the result slot is free, so it doubles as the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			now_q       <= POS_W'(RESET_POS);
			goal_q      <= POS_W'(RESET_POS);
			pins_q      <= upds_pkg::PINS_RESET;
		end else begin
			if (take) begin
				out_valid_q <= 1'b1;
				now_q       <= now_d;
				goal_q      <= goal_d;
				pins_q      <= pins_d;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/updown_pot_wiper_sequencer_top.sv */
// updown_pot_wiper_sequencer_top: top level of the up/down pot wiper sequencer
// depends on upds_pkg, upds_in_reg, upds_step, upds_state
`default_nettype none

// Drives one up/down digital potentiometer. Each command transaction (tick,
// set target, force to end B) yields one result transaction with the chip
// select and up/down pin levels, the assumed wiper position and a done flag.
// A command goes from the input register through the single next-state
// step into the state/result register; one command is taken every cycle
// while the result is not stalled. The state registers hold the result,
// so a stalled result holds the sequencer as well.
module updown_pot_wiper_sequencer_top #(
	parameter int unsigned MAX_POSITION = upds_pkg::MAX_POSITION_DEF,
	parameter int unsigned POS_W        = $clog2(MAX_POSITION + 1)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [1:0]       opcode,
	input  wire logic [7:0]       target_value,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic                  done_res,
	output logic                  chip_select_n,
	output logic                  up_down_level,
	output logic [POS_W-1:0]      wiper_position
);

	logic             valid_s1;
	logic [1:0]       opcode_s1;
	logic [7:0]       target_s1;
	logic             take;
	logic [POS_W-1:0] now_q;
	logic [POS_W-1:0] goal_q;
	logic [POS_W-1:0] now_d;
	logic [POS_W-1:0] goal_d;
	upds_pkg::pins_t  pins_q;
	upds_pkg::pins_t  pins_d;

	assign take = valid_s1 && (!out_valid || out_ready);

	upds_in_reg u_in_reg (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.opcode       (opcode),
		.target_value (target_value),
		.take         (take),
		.valid_s1     (valid_s1),
		.opcode_s1    (opcode_s1),
		.target_s1    (target_s1)
	);

	upds_step #(
		.MAX_POSITION (MAX_POSITION),
		.POS_W        (POS_W)
	) u_step (
		.opcode       (opcode_s1),
		.target_value (target_s1),
		.now_q        (now_q),
		.goal_q       (goal_q),
		.pins_q       (pins_q),
		.now_d        (now_d),
		.goal_d       (goal_d),
		.pins_d       (pins_d)
	);

	upds_state #(
		.MAX_POSITION (MAX_POSITION),
		.POS_W        (POS_W)
	) u_state (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.out_ready   (out_ready),
		.now_d       (now_d),
		.goal_d      (goal_d),
		.pins_d      (pins_d),
		.out_valid_q (out_valid),
		.now_q       (now_q),
		.goal_q      (goal_q),
		.pins_q      (pins_q)
	);

	assign done_res       = (now_q == goal_q);
	assign chip_select_n  = pins_q.cs;
	assign up_down_level  = pins_q.ud;
	assign wiper_position = now_q;

endmodule

`default_nettype wire

/* tb/sv/updown_pot_wiper_sequencer_top_tb.sv */
// updown_pot_wiper_sequencer_top_tb: self-checking bench for the up/down pot wiper sequencer
// drives command transactions with bursts and gaps and checks each result against a predictor
// depends on upds_pkg and updown_pot_wiper_sequencer_top
`timescale 1ns / 1ps

module updown_pot_wiper_sequencer_top_tb;

	localparam logic [1:0] OP_NOP = 2'd3;
	localparam logic [5:0] END_B_POS = 6'(upds_pkg::MAX_POSITION_DEF);
	localparam int RANDOM_ITEMS = 1900;
	localparam int CYCLE_LIMIT = 400000;
	localparam int LONG_HOLD_AT = 600;
	localparam int LONG_HOLD_LEN = 400;

	typedef struct {
		logic [1:0] op;
		logic [7:0] tv;
		bit         drain_first;
	} pot_cmd_t;

	typedef struct {
		logic       done;
		logic       cs_n;
		logic       ud;
		logic [5:0] pos;
	} pot_pins_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [1:0] opcode = OP_NOP;
	logic [7:0] target_value = 8'd0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       done_res;
	logic       chip_select_n;
	logic       up_down_level;
	logic [5:0] wiper_position;

	pot_cmd_t  cmd_pending[$];
	pot_pins_t pins_expected[$];
	int        mismatches = 0;
	int        cycle_count = 0;

	// predictor state
	logic [5:0]       pos_now = 6'(upds_pkg::POWER_UP_POS);
	logic [5:0]       pos_goal = 6'(upds_pkg::POWER_UP_POS);
	upds_pkg::phase_t seq_ph = upds_pkg::PH_IDLE;
	logic             ud_pin = 1'b0;
	logic             cs_pin = 1'b1;

	updown_pot_wiper_sequencer_top dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.opcode         (opcode),
		.target_value   (target_value),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.done_res       (done_res),
		.chip_select_n  (chip_select_n),
		.up_down_level  (up_down_level),
		.wiper_position (wiper_position)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic pot_pins_t advance_wiper(logic [1:0] op, logic [7:0] tv);
		pot_pins_t r;
		case (op)
			upds_pkg::OP_TICK: begin
				if (pos_now == pos_goal) begin
					cs_pin = 1'b1;
					seq_ph = upds_pkg::PH_IDLE;
				end else begin
					case (seq_ph)
						upds_pkg::PH_IDLE: begin
							ud_pin = (pos_goal > pos_now);
							seq_ph = upds_pkg::PH_DIR_SET;
						end
						upds_pkg::PH_DIR_SET: begin
							cs_pin = 1'b0;
							seq_ph = upds_pkg::PH_TO_LOAD;
						end
						upds_pkg::PH_TO_LOAD: begin
							ud_pin = ~ud_pin;
							seq_ph = upds_pkg::PH_TO_TRIGGER;
						end
						default: begin
							ud_pin = ~ud_pin;
							pos_now = (pos_goal > pos_now) ? pos_now + 6'd1 : pos_now - 6'd1;
							seq_ph = upds_pkg::PH_TO_LOAD;
						end
					endcase
				end
			end
			upds_pkg::OP_SET: begin
				if ($signed(tv) > $signed(8'(upds_pkg::MAX_POSITION_DEF)))
					pos_goal = END_B_POS;
				else if ($signed(tv) < 0)
					pos_goal = 6'd0;
				else
					pos_goal = tv[5:0];
			end
			upds_pkg::OP_FORCE_B: begin
				pos_now = END_B_POS;
				pos_goal = 6'd0;
			end
			default: ;
		endcase
		r.done = (pos_now == pos_goal);
		r.cs_n = cs_pin;
		r.ud = ud_pin;
		r.pos = pos_now;
		return r;
	endfunction

	task automatic queue_cmd(logic [1:0] op, logic [7:0] tv, bit drain_first = 0);
		pot_cmd_t c;
		c.op = op;
		c.tv = tv;
		c.drain_first = drain_first;
		cmd_pending.push_back(c);
	endtask

	task automatic queue_ticks(int n);
		repeat (n) queue_cmd(upds_pkg::OP_TICK, 8'($urandom_range(0, 255)));
	endtask

	task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
		if (exp_v != act_v) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, exp_v, act_v);
		end
	endtask

	// sender: bursts of random length separated by random gaps
	always @(posedge clk) begin
		int       gap_left;
		int       burst_left;
		logic     nv;
		pot_cmd_t c;
		if (arst_n) begin
			nv = in_valid;
			if (in_valid && in_ready) begin
				pins_expected.push_back(advance_wiper(opcode, target_value));
				nv = 1'b0;
			end
			if (!nv) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (cmd_pending.size() > 0 &&
						!(cmd_pending[0].drain_first && pins_expected.size() > 0)) begin
					c = cmd_pending.pop_front();
					opcode <= c.op;
					target_value <= c.tv;
					nv = 1'b1;
					if (burst_left > 0)
						burst_left--;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end
				end
			end
			in_valid <= nv;
		end
	end

	// receiver: stall pattern changes mode now and then, one long hold-off
	always @(posedge clk) begin
		int rx_cycle;
		int hold_left;
		int mode_left;
		int stall_mode;
		if (arst_n) begin
			rx_cycle++;
			if (rx_cycle == LONG_HOLD_AT)
				hold_left = LONG_HOLD_LEN;
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					stall_mode = $urandom_range(0, 2);
					mode_left = $urandom_range(20, 120);
				end else begin
					mode_left--;
				end
				case (stall_mode)
					0: out_ready <= 1'b1;
					1: out_ready <= 1'($urandom_range(0, 1));
					default: out_ready <= (rx_cycle % 4 == 0);
				endcase
			end
		end
	end

	// monitor: every result transaction is matched against the oldest expectation
	always @(posedge clk) begin
		pot_pins_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pins_expected.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result with no transaction pending", $realtime);
			end else begin
				e = pins_expected.pop_front();
				check_field("done_res", e.done, done_res);
				check_field("chip_select_n", e.cs_n, chip_select_n);
				check_field("up_down_level", e.ud, up_down_level);
				check_field("wiper_position", e.pos, wiper_position);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("updown_pot_wiper_sequencer_top_tb failed");
			$finish;
		end
	end

	initial begin
		int n;
		int r;
		bit drained;
		// directed: idle tick at target, noop, clamps, full move sequence
		queue_cmd(upds_pkg::OP_TICK, 8'h00);
		queue_cmd(OP_NOP, 8'hff);
		queue_cmd(upds_pkg::OP_SET, 8'h7f);
		queue_ticks(6);
		// retarget below the current position while a move is under way
		queue_cmd(upds_pkg::OP_SET, 8'h80);
		queue_ticks(4);
		queue_cmd(upds_pkg::OP_FORCE_B, 8'h55);
		queue_ticks(4);
		queue_cmd(upds_pkg::OP_SET, 8'd64);
		queue_cmd(upds_pkg::OP_TICK, 8'haa);
		queue_cmd(upds_pkg::OP_SET, 8'hff);
		queue_cmd(upds_pkg::OP_SET, 8'd63);
		queue_cmd(upds_pkg::OP_SET, 8'd0);
		queue_cmd(upds_pkg::OP_TICK, 8'h00);

		n = 0;
		drained = 1'b0;
		while (n < RANDOM_ITEMS) begin
			r = $urandom_range(0, 99);
			if (!drained && n > 900) begin
				// pause the sender until everything in flight has drained
				queue_cmd(upds_pkg::OP_SET, 8'($urandom_range(0, 63)), 1);
				drained = 1'b1;
				n++;
			end else if (r < 78) begin
				if ($urandom_range(0, 9) < 7)
					queue_cmd(upds_pkg::OP_SET, 8'($urandom_range(0, 63)));
				else
					queue_cmd(upds_pkg::OP_SET, 8'($urandom_range(0, 255)));
				r = $urandom_range(1, 140);
				queue_ticks(r);
				n += r + 1;
			end else if (r < 86) begin
				queue_cmd(upds_pkg::OP_FORCE_B, 8'($urandom_range(0, 255)));
				r = $urandom_range(1, 60);
				queue_ticks(r);
				n += r + 1;
			end else if (r < 94) begin
				queue_cmd(OP_NOP, 8'($urandom_range(0, 255)));
				n++;
			end else begin
				// back-to-back retargets with no ticks between them
				queue_cmd(upds_pkg::OP_SET, 8'($urandom_range(0, 255)));
				queue_cmd(upds_pkg::OP_SET, 8'($urandom_range(0, 255)));
				n += 2;
			end
		end

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		while (cmd_pending.size() > 0 || in_valid || pins_expected.size() > 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0 && pins_expected.size() == 0)
			$display("updown_pot_wiper_sequencer_top_tb passed");
		else
			$display("updown_pot_wiper_sequencer_top_tb failed");
		$finish;
	end

endmodule
